// ===== sv/pnm_ascii_stream_parser_top_macros.svh =====
// Assertion macros for the ASCII netpbm stream parser.
// Each check samples on clk; PNM_ASSERT stays quiet while rst_n is low.
`ifndef PNM_ASCII_STREAM_PARSER_TOP_MACROS_SVH
`define PNM_ASCII_STREAM_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define PNM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define PNM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PNM_ASSERT(lbl, prop, msg)

`define PNM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/pnm_asp_pkg.sv =====
`timescale 1ns / 1ps

package pnm_asp_pkg;

    // Event codes on the result channel.
    localparam logic [2:0] EV_WIDTH  = 3'd0;
    localparam logic [2:0] EV_HEIGHT = 3'd1;
    localparam logic [2:0] EV_MAXVAL = 3'd2;
    localparam logic [2:0] EV_SAMPLE = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_EARLY   = 3'd1;
    localparam logic [2:0] ERR_MAGIC   = 3'd2;
    localparam logic [2:0] ERR_MAXVAL  = 3'd3;
    localparam logic [2:0] ERR_BINARY  = 3'd4;

    // Magic digits with special handling.
    localparam logic [3:0] FMT_NONE      = 4'd0;
    localparam logic [3:0] FMT_PBM_ASCII = 4'd1;
    localparam logic [3:0] FMT_PGM_ASCII = 4'd2;
    localparam logic [3:0] FMT_PPM_ASCII = 4'd3;
    localparam logic [3:0] FMT_PGM_BIN   = 4'd5;
    localparam logic [3:0] FMT_PPM_BIN   = 4'd6;

    // Characters.
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_9       = 8'h39;

    // Fixed-width part of one result.
    typedef struct packed {
        logic [2:0] evt;
        logic [3:0] fmt;
        logic [1:0] comp;
        logic       last;
        logic [2:0] err;
    } res_info_t;

endpackage

// ===== sv/pnm_asp_core.sv =====
`timescale 1ns / 1ps

module pnm_asp_core
    import pnm_asp_pkg::*;
#(
    parameter int DIM_BITS   = 16,
    parameter int VALUE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            byte_in,
    input  logic                  eoi,
    input  logic                  sof,
    output logic                  rslt_valid,
    output res_info_t             rslt_info,
    output logic [VALUE_BITS-1:0] rslt_value,
    output logic [DIM_BITS-1:0]   rslt_col,
    output logic [DIM_BITS-1:0]   rslt_row
);

    localparam int SW = (VALUE_BITS > DIM_BITS) ? VALUE_BITS : DIM_BITS;
    localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};
    localparam logic [DIM_BITS-1:0]   DIM_MAX = {DIM_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_MAGIC1,
        PH_MAGIC2_OK,
        PH_MAGIC2_BAD,
        PH_HEADER,
        PH_DATA,
        PH_PENDING,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        LX_BETWEEN,
        LX_COMMENT,
        LX_NUMBER
    } lex_t;

    phase_t                phase_reg, phase_next, cur_phase;
    lex_t                  lex_reg, lex_next, cur_lex;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, cur_acc;
    logic                  innum_reg, innum_next, cur_innum;
    logic [1:0]            field_reg, field_next, cur_field;
    logic [3:0]            magic_reg, magic_next, cur_magic;
    logic [DIM_BITS-1:0]   width_reg, width_next, cur_width;
    logic [DIM_BITS-1:0]   height_reg, height_next, cur_height;
    logic [VALUE_BITS-1:0] maxv_reg, maxv_next, cur_maxv;
    logic [DIM_BITS-1:0]   col_reg, col_next, cur_col;
    logic [DIM_BITS-1:0]   row_reg, row_next, cur_row;
    logic [1:0]            comp_reg, comp_next, cur_comp;

    logic                  is_digit;
    logic [3:0]            digit_val;
    logic [VALUE_BITS+3:0] acc_x10;
    logic [VALUE_BITS-1:0] acc_push;
    logic [DIM_BITS-1:0]   acc_dim;
    logic [1:0]            comps_pp;
    logic                  is_final;
    logic [VALUE_BITS-1:0] smp_value;

    logic                  fail_req;
    logic [2:0]            fail_code;
    logic                  smp_req;
    logic                  hdr_req;
    logic [2:0]            hdr_evt;
    logic [VALUE_BITS-1:0] hdr_val;
    logic [2:0]            hdr_code;

    function automatic logic [2:0] hdr_outcome(input logic [3:0] mg,
                                               input logic [VALUE_BITS-1:0] mx);
        logic gray_ok;
        logic is_255;
        logic [2:0] code;
        is_255  = (mx == VALUE_BITS'(255));
        gray_ok = (mx == VALUE_BITS'(1)) || (mx == VALUE_BITS'(3)) ||
                  (mx == VALUE_BITS'(15)) || is_255;
        case (mg)
            FMT_PBM_ASCII: code = ERR_NONE;
            FMT_PGM_ASCII: code = gray_ok ? ERR_NONE : ERR_MAXVAL;
            FMT_PPM_ASCII: code = is_255 ? ERR_NONE : ERR_MAXVAL;
            FMT_PGM_BIN:   code = gray_ok ? ERR_BINARY : ERR_MAXVAL;
            FMT_PPM_BIN:   code = is_255 ? ERR_BINARY : ERR_MAXVAL;
            default:       code = ERR_BINARY;
        endcase
        return code;
    endfunction

    // Start of file clears everything before this byte is looked at.
    assign cur_phase  = sof ? PH_MAGIC1 : phase_reg;
    assign cur_lex    = sof ? LX_BETWEEN : lex_reg;
    assign cur_acc    = sof ? '0 : acc_reg;
    assign cur_innum  = sof ? 1'b0 : innum_reg;
    assign cur_field  = sof ? 2'd0 : field_reg;
    assign cur_magic  = sof ? FMT_NONE : magic_reg;
    assign cur_width  = sof ? '0 : width_reg;
    assign cur_height = sof ? '0 : height_reg;
    assign cur_maxv   = sof ? VALUE_BITS'(1) : maxv_reg;
    assign cur_col    = sof ? '0 : col_reg;
    assign cur_row    = sof ? '0 : row_reg;
    assign cur_comp   = sof ? 2'd0 : comp_reg;

    assign is_digit  = (byte_in >= CH_0) && (byte_in <= CH_9);
    assign digit_val = is_digit ? byte_in[3:0] : 4'd0;

    // acc * 10 + d, saturating
    assign acc_x10  = ({4'b0000, cur_acc} << 3) + ({4'b0000, cur_acc} << 1)
                    + (VALUE_BITS + 4)'(digit_val);
    assign acc_push = (acc_x10 > {4'b0000, VAL_MAX}) ? VAL_MAX : acc_x10[VALUE_BITS-1:0];

    assign acc_dim = (SW'(cur_acc) > SW'(DIM_MAX)) ? DIM_MAX : DIM_BITS'(cur_acc);

    assign comps_pp = (cur_magic == FMT_PPM_ASCII) ? 2'd3 : 2'd1;
    assign is_final = ({1'b0, cur_comp} + 3'd1 >= {1'b0, comps_pp}) &&
                      ({1'b0, cur_col} + (DIM_BITS + 1)'(1) >= {1'b0, cur_width}) &&
                      ({1'b0, cur_row} + (DIM_BITS + 1)'(1) >= {1'b0, cur_height});

    assign smp_value = (cur_magic == FMT_PBM_ASCII) ?
                       ((cur_acc == '0) ? VALUE_BITS'(1) : '0) :
                       ((cur_acc > cur_maxv) ? cur_maxv : cur_acc);

    always_comb
    begin
        phase_next  = cur_phase;
        lex_next    = cur_lex;
        acc_next    = cur_acc;
        innum_next  = cur_innum;
        field_next  = cur_field;
        magic_next  = cur_magic;
        width_next  = cur_width;
        height_next = cur_height;
        maxv_next   = cur_maxv;
        col_next    = cur_col;
        row_next    = cur_row;
        comp_next   = cur_comp;

        fail_req  = 1'b0;
        fail_code = ERR_NONE;
        smp_req   = 1'b0;
        hdr_req   = 1'b0;
        hdr_evt   = EV_WIDTH;
        hdr_val   = '0;
        hdr_code  = ERR_NONE;

        rslt_valid     = 1'b0;
        rslt_info.evt  = EV_WIDTH;
        rslt_info.fmt  = cur_magic;
        rslt_info.comp = 2'd0;
        rslt_info.last = 1'b0;
        rslt_info.err  = ERR_NONE;
        rslt_value     = '0;
        rslt_col       = '0;
        rslt_row       = '0;

        case (cur_phase)
            PH_MAGIC1:
            begin
                if (eoi)
                begin
                    fail_req  = 1'b1;
                    fail_code = ERR_EARLY;
                end
                else
                begin
                    phase_next = (byte_in == CH_P) ? PH_MAGIC2_OK : PH_MAGIC2_BAD;
                end
            end
            PH_MAGIC2_OK, PH_MAGIC2_BAD:
            begin
                if (eoi)
                begin
                    fail_req  = 1'b1;
                    fail_code = ERR_EARLY;
                end
                else if (cur_phase == PH_MAGIC2_OK && byte_in >= CH_1 && byte_in <= CH_9)
                begin
                    magic_next = byte_in[3:0];
                    phase_next = PH_HEADER;
                    lex_next   = LX_BETWEEN;
                end
                else
                begin
                    fail_req  = 1'b1;
                    fail_code = ERR_MAGIC;
                end
            end
            PH_HEADER:
            begin
                if (eoi)
                begin
                    fail_req  = 1'b1;
                    fail_code = ERR_EARLY;
                end
                else if (cur_lex == LX_COMMENT)
                begin
                    if (byte_in == CH_NEWLINE)
                    begin
                        lex_next = LX_BETWEEN;
                    end
                end
                else if (cur_lex != LX_NUMBER)
                begin
                    if (byte_in == CH_HASH)
                    begin
                        lex_next = LX_COMMENT;
                    end
                    else if (is_digit)
                    begin
                        acc_next = VALUE_BITS'(digit_val);
                        lex_next = LX_NUMBER;
                    end
                end
                else if (is_digit)
                begin
                    acc_next = acc_push;
                end
                else if (cur_field == 2'd0)
                begin
                    width_next     = acc_dim;
                    field_next     = 2'd1;
                    lex_next       = (byte_in == CH_HASH) ? LX_COMMENT : LX_BETWEEN;
                    rslt_valid     = 1'b1;
                    rslt_info.evt  = EV_WIDTH;
                    rslt_value     = VALUE_BITS'(acc_dim);
                end
                else if (cur_field == 2'd1)
                begin
                    height_next = acc_dim;
                    if (cur_magic == FMT_PBM_ASCII)
                    begin
                        hdr_req = 1'b1;
                        hdr_evt = EV_HEIGHT;
                        hdr_val = VALUE_BITS'(acc_dim);
                    end
                    else
                    begin
                        field_next    = 2'd2;
                        lex_next      = (byte_in == CH_HASH) ? LX_COMMENT : LX_BETWEEN;
                        rslt_valid    = 1'b1;
                        rslt_info.evt = EV_HEIGHT;
                        rslt_value    = VALUE_BITS'(acc_dim);
                    end
                end
                else
                begin
                    maxv_next = cur_acc;
                    hdr_req   = 1'b1;
                    hdr_evt   = EV_MAXVAL;
                    hdr_val   = cur_acc;
                end
            end
            PH_DATA:
            begin
                if (eoi)
                begin
                    if (cur_innum && is_final)
                    begin
                        smp_req = 1'b1;
                    end
                    else
                    begin
                        fail_req  = 1'b1;
                        fail_code = ERR_EARLY;
                    end
                end
                else if (is_digit)
                begin
                    acc_next   = cur_innum ? acc_push : VALUE_BITS'(digit_val);
                    innum_next = 1'b1;
                end
                else if (cur_innum)
                begin
                    smp_req = 1'b1;
                end
            end
            PH_PENDING:
            begin
                fail_req  = 1'b1;
                fail_code = hdr_outcome(cur_magic, cur_maxv);
            end
            default:
            begin
                // finished file: drop everything until start of file
            end
        endcase

        if (hdr_req)
        begin
            hdr_code = hdr_outcome(cur_magic, maxv_next);
            if (hdr_code != ERR_NONE)
            begin
                phase_next = PH_PENDING;
            end
            else if (width_next == '0 || height_next == '0)
            begin
                phase_next     = PH_DONE;
                rslt_info.last = 1'b1;
            end
            else
            begin
                phase_next = PH_DATA;
            end
            lex_next      = LX_BETWEEN;
            acc_next      = '0;
            innum_next    = 1'b0;
            rslt_valid    = 1'b1;
            rslt_info.evt = hdr_evt;
            rslt_value    = hdr_val;
        end

        if (smp_req)
        begin
            rslt_valid     = 1'b1;
            rslt_info.evt  = EV_SAMPLE;
            rslt_info.comp = cur_comp;
            rslt_info.last = is_final;
            rslt_value     = smp_value;
            rslt_col       = cur_col;
            rslt_row       = cur_row;
            if (is_final)
            begin
                phase_next = PH_DONE;
            end
            else if (cur_comp + 2'd1 >= comps_pp)
            begin
                comp_next = 2'd0;
                if ({1'b0, cur_col} + (DIM_BITS + 1)'(1) >= {1'b0, cur_width})
                begin
                    col_next = '0;
                    row_next = cur_row + DIM_BITS'(1);
                end
                else
                begin
                    col_next = cur_col + DIM_BITS'(1);
                end
            end
            else
            begin
                comp_next = cur_comp + 2'd1;
            end
            acc_next   = '0;
            innum_next = 1'b0;
        end

        if (fail_req)
        begin
            phase_next     = PH_DONE;
            rslt_valid     = 1'b1;
            rslt_info.evt  = EV_ERROR;
            rslt_info.last = 1'b1;
            rslt_info.err  = fail_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC1;
            lex_reg    <= LX_BETWEEN;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            field_reg  <= 2'd0;
            magic_reg  <= FMT_NONE;
            width_reg  <= '0;
            height_reg <= '0;
            maxv_reg   <= VALUE_BITS'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            comp_reg   <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            lex_reg    <= lex_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            field_reg  <= field_next;
            magic_reg  <= magic_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            maxv_reg   <= maxv_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            comp_reg   <= comp_next;
        end
    end

endmodule

// ===== sv/pnm_ascii_stream_parser_top.sv =====
`timescale 1ns / 1ps
// ASCII netpbm (P1/P2/P3) stream parser.
// Input channel: one file byte per request on data_byte, with end_of_input
//   marking the end of the file (no byte carried) and start_of_file clearing
//   all parser state before the byte is handled. Handshake src_valid/src_stall.
// Result channel: zero or one event per input request (width, height, max
//   value, sample with column/row/component, or error), handshake
//   res_valid/res_stall. last_item marks the event that finishes a file; after
//   it every request is dropped until a request with start_of_file.
// Path: a taken request is held in the input register until it can advance,
//   then one pass of parser logic writes its event into the result
//   register, which drives the result ports.
// Throughput: one byte per cycle while no event waits on a stalled result;
//   the parser state updates once per taken byte; there is no iterative unit.
// Stall: while res_stall holds a pending event, the input register still takes
//   one more request; a byte that makes no event advances past a stalled
//   result, a byte that makes one waits and src_stall rises.
// Reset: rst_n clears both registers' valid flags and puts the parser at the
//   first magic byte; no clearing pass is needed.
`include "pnm_ascii_stream_parser_top_macros.svh"

module pnm_ascii_stream_parser_top
    import pnm_asp_pkg::*;
#(
    parameter int DIM_BITS   = 16,
    parameter int VALUE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_input,
    input  logic                  start_of_file,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [2:0]            event_res,
    output logic [VALUE_BITS-1:0] value,
    output logic [3:0]            format,
    output logic [1:0]            component,
    output logic [DIM_BITS-1:0]   column,
    output logic [DIM_BITS-1:0]   row,
    output logic                  last_item,
    output logic [2:0]            error_code
);

    // input register
    logic       in_v_reg;
    logic [7:0] byte_reg;
    logic       eoi_reg;
    logic       sof_reg;

    // result register
    logic                  out_v_reg;
    res_info_t             info_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [DIM_BITS-1:0]   col_reg;
    logic [DIM_BITS-1:0]   row_reg;

    logic                  core_valid;
    res_info_t             core_info;
    logic [VALUE_BITS-1:0] core_value;
    logic [DIM_BITS-1:0]   core_col;
    logic [DIM_BITS-1:0]   core_row;

    logic out_free;
    logic advance;
    logic take_in;

    // The result slot is free when empty or being drained this cycle.
    assign out_free = !out_v_reg || !res_stall;
    // Advance the held request unless it makes an event and the slot is full.
    assign advance  = in_v_reg && (out_free || !core_valid);
    assign src_stall = in_v_reg && !advance;
    assign take_in  = src_valid && !src_stall;

    pnm_asp_core #(
        .DIM_BITS   (DIM_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .byte_in    (byte_reg),
        .eoi        (eoi_reg),
        .sof        (sof_reg),
        .rslt_valid (core_valid),
        .rslt_info  (core_info),
        .rslt_value (core_value),
        .rslt_col   (core_col),
        .rslt_row   (core_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_v_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_v_reg <= 1'b0;
            end

            if (advance && core_valid)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
            sof_reg  <= start_of_file;
        end
        if (advance && core_valid)
        begin
            info_reg  <= core_info;
            value_reg <= core_value;
            col_reg   <= core_col;
            row_reg   <= core_row;
        end
    end

    assign res_valid  = out_v_reg;
    assign event_res  = info_reg.evt;
    assign value      = value_reg;
    assign format     = info_reg.fmt;
    assign component  = info_reg.comp;
    assign column     = col_reg;
    assign row        = row_reg;
    assign last_item  = info_reg.last;
    assign error_code = info_reg.err;

    // An event never overwrites a result that is still stalled.
    `PNM_ASSERT(a_no_overwrite, (out_v_reg && res_stall) |-> !(advance && core_valid), "result overwritten while stalled")
    // Errors always carry a code and close the file; other events carry none.
    `PNM_ASSERT(a_err_shape, (out_v_reg && info_reg.evt == EV_ERROR) |-> (info_reg.err != ERR_NONE && info_reg.last), "malformed error event")
    `PNM_ASSERT(a_err_only, (out_v_reg && info_reg.evt != EV_ERROR) |-> (info_reg.err == ERR_NONE), "error code on a non-error event")
    // Header and error events carry no position.
    `PNM_ASSERT(a_pos_zero, (out_v_reg && info_reg.evt != EV_SAMPLE) |-> (col_reg == '0 && row_reg == '0 && info_reg.comp == 2'd0), "position on a non-sample event")
    // Nothing is held in either register right after reset.
    `PNM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!res_valid && !src_stall) || rst_n, "pipeline not empty after reset")

endmodule

// ===== verif/pnm_ascii_stream_parser_top_tb.sv =====
`timescale 1ns / 1ps

module pnm_ascii_stream_parser_top_tb
    import pnm_asp_pkg::*;
();

    // Stop the run when nothing is accepted on either channel for this long
    // while work is still outstanding.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // Cycles to keep watching the result channel once nothing is expected.
    localparam int unsigned DRAIN_CYCLES   = 20;
    // Input requests for the random part.
    localparam int unsigned RANDOM_BYTES   = 650;
    localparam logic [15:0] VALUE_MAX      = 16'hFFFF;

    // Parser position, as the block walks through one file.
    typedef enum logic [2:0] {
        PS_MAGIC1,
        PS_MAGIC2_OK,
        PS_MAGIC2_BAD,
        PS_HEADER,
        PS_DATA,
        PS_PENDING,
        PS_DONE
    } parse_phase_t;

    // Header tokenizer mode.
    typedef enum logic [1:0] {
        LEX_SPACE,
        LEX_COMMENT,
        LEX_NUMBER
    } token_mode_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        logic       sof;
    } byte_request_t;

    typedef struct {
        logic [2:0]  evt;
        logic [15:0] val;
        logic [3:0]  fmt;
        logic [1:0]  comp;
        logic [15:0] col;
        logic [15:0] row;
        logic        last;
        logic [2:0]  err;
    } pnm_event_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        src_valid     = 1'b0;
    logic [7:0]  data_byte     = 8'h00;
    logic        end_of_input  = 1'b0;
    logic        start_of_file = 1'b0;
    logic        res_stall     = 1'b0;
    logic        src_stall;
    logic        res_valid;
    logic [2:0]  event_res;
    logic [15:0] value;
    logic [3:0]  format;
    logic [1:0]  component;
    logic [15:0] column;
    logic [15:0] row;
    logic        last_item;
    logic [2:0]  error_code;

    // Requests still to be driven, and events the parser must still produce.
    byte_request_t pending_requests[$];
    pnm_event_t    expected_events[$];
    int unsigned   mismatch_count = 0;

    // Sender burst/gap shaping.
    int unsigned burst_left;
    int unsigned gap_left;

    // Receiver stall pattern state.
    stall_mode_t stall_mode;
    int unsigned stall_left;
    logic [1:0]  stall_tick;

    // Shadow copy of the parser state.
    parse_phase_t parse_phase;
    token_mode_t  token_mode;
    logic [15:0]  acc;
    logic         in_num;
    logic [1:0]   field_idx;
    logic [3:0]   magic;
    logic [15:0]  img_w;
    logic [15:0]  img_h;
    logic [15:0]  max_val;
    logic [15:0]  col_cnt;
    logic [15:0]  row_cnt;
    logic [1:0]   comp_cnt;

    pnm_ascii_stream_parser_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .data_byte     (data_byte),
        .end_of_input  (end_of_input),
        .start_of_file (start_of_file),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .event_res     (event_res),
        .value         (value),
        .format        (format),
        .component     (component),
        .column        (column),
        .row           (row),
        .last_item     (last_item),
        .error_code    (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: the parser's behavior, one request at a time.
    // ------------------------------------------------------------------

    // Append one decimal digit, saturating at the top of the value range.
    function automatic logic [15:0] acc_digit(input logic [15:0] a, input logic [3:0] d);
        int unsigned v;
        v = a * 10 + d;
        return (v > VALUE_MAX) ? VALUE_MAX : v[15:0];
    endfunction

    // Error the header leads to for a given magic digit and max value.
    function automatic logic [2:0] max_code(input logic [3:0] f, input logic [15:0] mx);
        logic gray_ok;
        gray_ok = (mx == 1) || (mx == 3) || (mx == 15) || (mx == 255);
        case (f)
            FMT_PBM_ASCII: return ERR_NONE;
            FMT_PGM_ASCII: return gray_ok ? ERR_NONE : ERR_MAXVAL;
            FMT_PPM_ASCII: return (mx == 255) ? ERR_NONE : ERR_MAXVAL;
            FMT_PGM_BIN:   return gray_ok ? ERR_BINARY : ERR_MAXVAL;
            FMT_PPM_BIN:   return (mx == 255) ? ERR_BINARY : ERR_MAXVAL;
            default:       return ERR_BINARY;
        endcase
    endfunction

    function automatic int samples_per_pixel();
        return (magic == FMT_PPM_ASCII) ? 3 : 1;
    endfunction

    // True when the sample being finished is the last one of the image.
    function automatic logic last_sample();
        return (int'(comp_cnt) + 1 >= samples_per_pixel()) &&
               (int'(col_cnt) + 1 >= int'(img_w)) &&
               (int'(row_cnt) + 1 >= int'(img_h));
    endfunction

    task automatic clear_parser();
        parse_phase = PS_MAGIC1;
        token_mode  = LEX_SPACE;
        acc         = '0;
        in_num      = 1'b0;
        field_idx   = '0;
        magic       = FMT_NONE;
        img_w       = '0;
        img_h       = '0;
        max_val     = 16'd1;
        col_cnt     = '0;
        row_cnt     = '0;
        comp_cnt    = '0;
    endtask

    task automatic note_event(input logic [2:0] evt, input logic [15:0] val,
                              input logic [1:0] comp, input logic [15:0] col,
                              input logic [15:0] rw, input logic last,
                              input logic [2:0] err);
        pnm_event_t e;
        e.evt  = evt;
        e.val  = val;
        e.fmt  = magic;
        e.comp = comp;
        e.col  = col;
        e.row  = rw;
        e.last = last;
        e.err  = err;
        expected_events.push_back(e);
    endtask

    task automatic fail_file(input logic [2:0] code);
        note_event(EV_ERROR, '0, '0, '0, '0, 1'b1, code);
        parse_phase = PS_DONE;
    endtask

    task automatic finish_header(input logic [2:0] evt, input logic [15:0] val);
        logic last_flag;
        last_flag = 1'b0;
        if (max_code(magic, max_val) != ERR_NONE)
            parse_phase = PS_PENDING;
        else if (img_w == 0 || img_h == 0)
        begin
            parse_phase = PS_DONE;
            last_flag   = 1'b1;
        end
        else
            parse_phase = PS_DATA;
        token_mode = LEX_SPACE;
        acc        = '0;
        in_num     = 1'b0;
        note_event(evt, val, '0, '0, '0, last_flag, ERR_NONE);
    endtask

    task automatic emit_sample();
        logic        fin;
        logic [15:0] v;
        fin = last_sample();
        if (magic == FMT_PBM_ASCII)
            v = (acc == 0) ? 16'd1 : 16'd0;
        else
            v = (acc > max_val) ? max_val : acc;
        note_event(EV_SAMPLE, v, comp_cnt, col_cnt, row_cnt, fin, ERR_NONE);
        if (fin)
            parse_phase = PS_DONE;
        else if (int'(comp_cnt) + 1 >= samples_per_pixel())
        begin
            comp_cnt = '0;
            if (int'(col_cnt) + 1 >= int'(img_w))
            begin
                col_cnt = '0;
                row_cnt = row_cnt + 16'd1;
            end
            else
                col_cnt = col_cnt + 16'd1;
        end
        else
            comp_cnt = comp_cnt + 2'd1;
        acc    = '0;
        in_num = 1'b0;
    endtask

    // Advance the shadow parser by one accepted request.
    task automatic predict_request(input logic [7:0] b, input logic eoi, input logic sof);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (b >= CH_0) && (b <= CH_9);
        d        = is_digit ? b[3:0] : 4'd0;
        if (sof)
            clear_parser();
        case (parse_phase)
            PS_MAGIC1:
                if (eoi)
                    fail_file(ERR_EARLY);
                else if (b == CH_P)
                    parse_phase = PS_MAGIC2_OK;
                else
                    parse_phase = PS_MAGIC2_BAD;
            PS_MAGIC2_OK, PS_MAGIC2_BAD:
                if (eoi)
                    fail_file(ERR_EARLY);
                else if (parse_phase == PS_MAGIC2_OK && b >= CH_1 && b <= CH_9)
                begin
                    magic       = b[3:0];
                    parse_phase = PS_HEADER;
                    token_mode  = LEX_SPACE;
                end
                else
                    fail_file(ERR_MAGIC);
            PS_HEADER:
                if (eoi)
                    fail_file(ERR_EARLY);
                else if (token_mode == LEX_COMMENT)
                begin
                    if (b == CH_NEWLINE)
                        token_mode = LEX_SPACE;
                end
                else if (token_mode != LEX_NUMBER)
                begin
                    if (b == CH_HASH)
                        token_mode = LEX_COMMENT;
                    else if (is_digit)
                    begin
                        acc        = {12'd0, d};
                        token_mode = LEX_NUMBER;
                    end
                end
                else if (is_digit)
                    acc = acc_digit(acc, d);
                else if (field_idx == 2'd0)
                begin
                    img_w      = acc;
                    field_idx  = 2'd1;
                    token_mode = (b == CH_HASH) ? LEX_COMMENT : LEX_SPACE;
                    note_event(EV_WIDTH, img_w, '0, '0, '0, 1'b0, ERR_NONE);
                end
                else if (field_idx == 2'd1)
                begin
                    img_h = acc;
                    if (magic == FMT_PBM_ASCII)
                        finish_header(EV_HEIGHT, img_h);
                    else
                    begin
                        field_idx  = 2'd2;
                        token_mode = (b == CH_HASH) ? LEX_COMMENT : LEX_SPACE;
                        note_event(EV_HEIGHT, img_h, '0, '0, '0, 1'b0, ERR_NONE);
                    end
                end
                else
                begin
                    max_val = acc;
                    finish_header(EV_MAXVAL, max_val);
                end
            PS_DATA:
                if (eoi)
                begin
                    // A number cut by the end only counts if it is the last sample.
                    if (in_num && last_sample())
                        emit_sample();
                    else
                        fail_file(ERR_EARLY);
                end
                else if (is_digit)
                begin
                    acc    = in_num ? acc_digit(acc, d) : {12'd0, d};
                    in_num = 1'b1;
                end
                else if (in_num)
                    emit_sample();
            PS_PENDING:
                // The header error shows one request after the header ends.
                fail_file(max_code(magic, max_val));
            default:
                ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders: append requests to the pending queue.
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b, input logic sof);
        byte_request_t r;
        r.data = b;
        r.eoi  = 1'b0;
        r.sof  = sof;
        pending_requests.push_back(r);
    endtask

    // End of file: the data byte is noise and must be ignored.
    task automatic queue_end(input logic sof);
        byte_request_t r;
        r.data = 8'($urandom_range(0, 255));
        r.eoi  = 1'b1;
        r.sof  = sof;
        pending_requests.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], 1'b0);
    endtask

    // Open a new file: the first byte carries start_of_file.
    task automatic queue_file(input string s);
        queue_byte(s[0], 1'b1);
        queue_text(s.substr(1, s.len() - 1));
    endtask

    task automatic queue_number(input int unsigned n);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                queue_byte(CH_0, 1'b0);
        queue_text($sformatf("%0d", n));
    endtask

    // Separator run. Comments only in the header: in the data part their
    // digits would be read as samples.
    task automatic queue_separator(input bit in_header);
        int unsigned kind;
        logic [7:0]  b;
        repeat ($urandom_range(1, 3))
        begin
            kind = $urandom_range(0, 9);
            if (in_header && kind == 0)
                queue_text("# note 12\n");
            else if (kind <= 6)
            begin
                case ($urandom_range(0, 3))
                    0:       b = 8'h20;
                    1:       b = 8'h09;
                    2:       b = CH_NEWLINE;
                    default: b = 8'h0D;
                endcase
                queue_byte(b, 1'b0);
            end
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= CH_0 && b <= CH_9) || (in_header && b == CH_HASH));
                queue_byte(b, 1'b0);
            end
        end
    endtask

    // One file with random content, possibly malformed, and a random way of ending.
    task automatic queue_random_image();
        int unsigned fmt, w, h, mx, total, stop_at, sample, ending, r;
        logic [15:0] mx_sat;
        r = $urandom_range(0, 19);
        if (r < 6)
            fmt = 1;
        else if (r < 12)
            fmt = 2;
        else if (r < 17)
            fmt = 3;
        else
            fmt = $urandom_range(4, 9);
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            7:       mx = $urandom_range(0, 300);
            8:       mx = $urandom_range(0, 1) ? 65535 : 70000;
            9:       mx = $urandom_range(0, 20);
            default:
                case ($urandom_range(0, 3))
                    0:       mx = 1;
                    1:       mx = 3;
                    2:       mx = 15;
                    default: mx = 255;
                endcase
        endcase
        if (fmt == 3 && $urandom_range(0, 3) != 0)
            mx = 255;
        mx_sat = (mx > VALUE_MAX) ? VALUE_MAX : mx[15:0];
        ending = $urandom_range(0, 9);

        queue_byte(CH_P, 1'b1);
        queue_byte(CH_0 + fmt[7:0], 1'b0);
        if ($urandom_range(0, 1))
            queue_separator(1'b1);
        queue_number(w);
        if (ending == 0)
        begin
            // Cut the file inside the header.
            queue_end(1'b0);
            return;
        end
        queue_separator(1'b1);
        queue_number(h);
        if (fmt != 1)
        begin
            queue_separator(1'b1);
            queue_number(mx);
        end
        queue_separator(1'b0);

        if (max_code(fmt[3:0], mx_sat) != ERR_NONE || w == 0 || h == 0)
        begin
            // Feed the request that carries a pending header error, or junk.
            if ($urandom_range(0, 3) == 0)
                queue_end(1'b0);
            else
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end

        total   = w * h * ((fmt == 3) ? 3 : 1);
        stop_at = $urandom_range(0, total - 1);
        for (int unsigned k = 0; k < total; k++)
        begin
            if (ending == 1 && k == stop_at)
            begin
                if ($urandom_range(0, 1))
                    queue_number($urandom_range(0, 300));
                queue_end(1'b0);
                return;
            end
            if (fmt == 1)
                sample = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 99999)
                                                      : $urandom_range(0, 1);
            else
                case ($urandom_range(0, 9))
                    5, 6, 7: sample = $urandom_range(0, 20);
                    8:       sample = $urandom_range(0, 70000);
                    9:       sample = $urandom_range(100000, 32'hEE6B2800);
                    default: sample = $urandom_range(0, mx_sat);
                endcase
            queue_number(sample);
            if (ending == 2 && k == total - 1)
            begin
                // End the file right inside the last number.
                queue_end(1'b0);
                return;
            end
            queue_separator(1'b0);
        end
        repeat ($urandom_range(0, 3))
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Random bytes with the occasional restart or end marker.
    task automatic queue_noise();
        byte_request_t req;
        repeat ($urandom_range(1, 10))
        begin
            req.data = 8'($urandom_range(0, 255));
            req.sof  = ($urandom_range(0, 9) == 0);
            req.eoi  = ($urandom_range(0, 9) == 0);
            pending_requests.push_back(req);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps.
    // Hold the payload while the block stalls; predict each accepted request.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        byte_request_t next_req;
        if (!rst_n)
        begin
            src_valid     <= 1'b0;
            data_byte     <= 8'h00;
            end_of_input  <= 1'b0;
            start_of_file <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else if (!(src_valid && src_stall))
        begin
            if (src_valid)
                predict_request(data_byte, end_of_input, start_of_file);
            if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                src_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                src_valid     <= 1'b1;
                data_byte     <= next_req.data;
                end_of_input  <= next_req.eoi;
                start_of_file <= next_req.sof;
                if (burst_left <= 1)
                begin
                    // Mostly short bursts, now and then a long unbroken stretch.
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                src_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result stall pattern: switch at random times between no stall, coin flip,
    // heavy and periodic stalling.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_mode <= STALL_NONE;
            stall_left <= 0;
            stall_tick <= '0;
        end
        else
        begin
            stall_tick <= stall_tick + 2'd1;
            if (stall_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                stall_left <= $urandom_range(16, 200);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                STALL_NONE:  res_stall <= 1'b0;
                STALL_COIN:  res_stall <= 1'($urandom_range(0, 1));
                STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 8);
                default:     res_stall <= (stall_tick != 2'd0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted event with the oldest expected.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        pnm_event_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event, expected none, actual event %0d value %0d",
                         $time, event_res, value);
                mismatch_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                check_field("event_res", 16'(want.evt), 16'(event_res));
                check_field("value", want.val, value);
                check_field("format", 16'(want.fmt), 16'(format));
                check_field("component", 16'(want.comp), 16'(component));
                check_field("column", want.col, column);
                check_field("row", want.row, row);
                check_field("last_item", 16'(want.last), 16'(last_item));
                check_field("error_code", 16'(want.err), 16'(error_code));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with work outstanding but no request or result
    // moving; end the run when the count hits the limit.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (src_valid && !src_stall) || (res_valid && !res_stall) ||
                (pending_requests.size() == 0 && !src_valid && expected_events.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: build the whole stimulus, release reset, wait for the
    // queues to drain, then report.
    // ------------------------------------------------------------------
    initial
    begin
        clear_parser();

        // Directed files.
        queue_end(1'b1);                          // end before any byte
        queue_file("X1z");                        // bad first magic byte
        queue_file("P0");                         // bad magic digit
        queue_file("P");                          // end between magic bytes
        queue_end(1'b0);
        queue_file("P1\n# c 9\n2 1\n0 7\n9");     // bitmap, inverted samples, trailing byte
        queue_file("P2 1 2#x\n255 300 99999 ");   // hash ends a number, clamp, saturation
        queue_file("P3 1 1 255 1 2 3");           // last sample cut by end of file
        queue_end(1'b0);
        queue_file("P2 2 2 15 1 2 ");             // early end in the data
        queue_end(1'b0);
        queue_file("P2 1 1 7 x");                 // unsupported gray max value
        queue_file("P3 1 1 15 x");                // unsupported color max value
        queue_file("P5 1 1 255 x");               // binary gray
        queue_file("P6 1 1 15 ");                 // binary color, bad max, then end
        queue_end(1'b0);
        queue_file("P4 1 1 1 x");                 // binary bitmap
        queue_file("P9 2 2 3 x");                 // unknown format digit
        queue_file("P2 0 5 255 z");               // empty image, zero width
        queue_file("P1 3 0 z");                   // empty bitmap, zero height
        queue_file("P2 70000 99999 255 ");        // saturated dimensions, then end
        queue_end(1'b0);
        queue_file("P2 3");                       // end inside a header number
        queue_end(1'b0);
        queue_file("P2");                         // high bytes as separators
        queue_byte(8'hFF, 1'b0);
        queue_text("1");
        queue_byte(8'h80, 1'b0);
        queue_text("1 3 0");
        queue_byte(8'hC5, 1'b0);
        queue_file("P2 2 1 255 5");               // restart in the middle of a file
        queue_file("P1 1 1 1 ");

        // Random part: mostly well-formed files, some noise.
        begin : random_part
            int unsigned target;
            target = pending_requests.size() + RANDOM_BYTES;
            while (pending_requests.size() < target)
            begin
                if ($urandom_range(0, 9) < 8)
                    queue_random_image();
                else
                    queue_noise();
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every request is taken and every event has come back.
        while (pending_requests.size() != 0 || src_valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        // Keep watching the result channel for stray events before reporting.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pnm_asp_pkg.sv
sv/pnm_asp_core.sv
sv/pnm_ascii_stream_parser_top.sv
verif/pnm_ascii_stream_parser_top_tb.sv
